// ===== sv/swkf_pkg.sv =====
// ----------------------------------------------------------------------------
// swkf_pkg
// shared types and constants of the sliding window kth order filter
// ----------------------------------------------------------------------------
package swkf_pkg;

    localparam int SAMPLE_W     = 12;
    localparam int CFG_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int SEEN_W       = 7;
    localparam int COUNT_W      = 7;
    localparam int DEF_SAMPLE_LEVELS = 4096;
    localparam int DEF_HISTORY_DEPTH = 64;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KTH_INDEX    = 2'd2;

    localparam logic signed [CFG_W-1:0] RST_LEFT_OFFSET  = -6'sd1;
    localparam logic signed [CFG_W-1:0] RST_RIGHT_OFFSET = 6'sd1;
    localparam logic [CFG_W-1:0]        RST_KTH_INDEX    = 6'd1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                line_end;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] order_value;
        logic                line_done;
        logic                run_last;
    } out_item_t;

endpackage

// ===== sv/swkf_ram.sv =====
// ----------------------------------------------------------------------------
// swkf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module swkf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/sliding_window_kth_order_filter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kth_order_filter
// kth order statistic over a sliding window of one line of samples
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (sample, line_end)
//  out     | output    | out_valid / out_ready| out_data (order_value, line_done, run_last)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  each result is set by a bitwise search of the value (msb first) that counts
//  window samples below a trial value, one history ram read per sample per bit
//  reset clears control state and the line state; the history ram is not cleared
//  a stalled output holds only the finished result; the next search starts
//  while it waits, and a new input item is taken once all searches are done
// ----------------------------------------------------------------------------
module sliding_window_kth_order_filter
    import swkf_pkg::*;
#(
    parameter int SAMPLE_LEVELS = swkf_pkg::DEF_SAMPLE_LEVELS,
    parameter int HISTORY_DEPTH = swkf_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  swkf_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output swkf_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [swkf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swkf_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int BIT_W = 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // d mod depth for every history distance the window can reach
    logic [AW-1:0] mod_tab [64];
    for (genvar g = 0; g < 64; g++)
    begin : g_mod
        assign mod_tab[g] = AW'(g % HISTORY_DEPTH);
    end

    // configuration
    logic signed [CFG_W-1:0] left_reg, right_reg;
    logic [CFG_W-1:0]        kth_reg;

    // line state
    logic [SAMPLE_W-1:0] first_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [AW-1:0]       wr_ptr_reg;

    // search state
    logic [1:0]              state_reg, state_next;
    logic signed [CFG_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0]      n_reg, n_next;
    logic [CFG_W-1:0]        k_reg, k_next;
    logic [CFG_W-1:0]        b_reg, b_next;
    logic                    last_reg, last_next;
    logic [AW-1:0]           newest_reg, newest_next;
    logic [SEEN_W-1:0]       wseen_reg, wseen_next;
    logic [SAMPLE_W-1:0]     wfirst_reg, wfirst_next;
    logic [COUNT_W-1:0]      e_reg, e_next;
    logic [BIT_W-1:0]        bit_reg, bit_next;
    logic [SAMPLE_W-1:0]     r_reg, r_next;
    logic [COUNT_W-1:0]      cnt_reg, cnt_next;
    logic                    p_valid_reg, p_valid_next;
    logic                    p_first_reg, p_first_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    logic                in_fire;
    logic [SAMPLE_W-1:0] s_sat, ram_rdata;
    logic [AW-1:0]       raddr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        s_sat = in_data.sample;
        if (32'(in_data.sample) >= SAMPLE_LEVELS)
        begin
            s_sat = SAMPLE_W'(SAMPLE_LEVELS - 1);
        end
    end

    swkf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (in_fire),
        .waddr (wr_ptr_reg),
        .wdata (s_sat),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // window setup from the live configuration
    logic signed [CFG_W-1:0] hi_c;
    logic [CFG_W-2:0]        lag_c;
    logic [SEEN_W-1:0]       seen_new;
    logic [COUNT_W-1:0]      n_c;
    logic [CFG_W-1:0]        b0_c;

    always_comb
    begin
        hi_c     = (right_reg < left_reg) ? left_reg : right_reg;
        lag_c    = hi_c[CFG_W-1] ? '0 : hi_c[CFG_W-2:0];
        seen_new = (seen_reg == SEEN_MAX) ? SEEN_MAX : seen_reg + 1'b1;
        n_c      = COUNT_W'(7'(signed'(hi_c)) - 7'(signed'(left_reg)) + 7'sd1);
        b0_c     = ({2'b00, lag_c} < seen_new) ? {1'b0, lag_c} : CFG_W'(seen_new - 1'b1);
    end

    // address of window element e of the current position
    logic signed [8:0] off_c, d_c;
    logic [CFG_W-1:0]  dcl_c;
    logic              first_c;
    logic [AW:0]       sum_c;

    always_comb
    begin
        off_c   = 9'(lo_reg) + signed'({2'b00, e_reg});
        d_c     = signed'({3'b000, b_reg}) - off_c;
        dcl_c   = d_c[8] ? '0 : d_c[CFG_W-1:0];
        first_c = ({1'b0, dcl_c} >= wseen_reg);
        sum_c   = {1'b0, newest_reg} + (AW+1)'(HISTORY_DEPTH) - {1'b0, mod_tab[dcl_c]};
        if (sum_c >= (AW+1)'(HISTORY_DEPTH))
        begin
            sum_c = sum_c - (AW+1)'(HISTORY_DEPTH);
        end
        raddr = sum_c[AW-1:0];
    end

    // compare of the returning window sample against the trial value
    logic [SAMPLE_W-1:0] trial_c, val_c;
    logic                hit_c;
    logic [COUNT_W-1:0]  total_c;

    always_comb
    begin
        trial_c = r_reg | (SAMPLE_W'(1) << bit_reg);
        val_c   = p_first_reg ? wfirst_reg : ram_rdata;
        hit_c   = p_valid_reg && (val_c < trial_c);
        total_c = cnt_reg + COUNT_W'(hit_c);
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        newest_next    = newest_reg;
        wseen_next     = wseen_reg;
        wfirst_next    = wfirst_reg;
        e_next         = e_reg;
        bit_next       = bit_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        p_valid_next   = 1'b0;
        p_first_next   = p_first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    lo_next     = left_reg;
                    n_next      = n_c;
                    k_next      = ({1'b0, kth_reg} > n_c - 1'b1) ? CFG_W'(n_c - 1'b1) : kth_reg;
                    last_next   = in_data.line_end;
                    newest_next = wr_ptr_reg;
                    wseen_next  = seen_new;
                    wfirst_next = (seen_reg == '0) ? s_sat : first_reg;
                    e_next      = '0;
                    bit_next    = BIT_W'(SAMPLE_W - 1);
                    r_next      = '0;
                    cnt_next    = '0;
                    if (in_data.line_end)
                    begin
                        b_next     = b0_c;
                        state_next = ST_SCAN;
                    end
                    else if (seen_new > {2'b00, lag_c})
                    begin
                        b_next     = {1'b0, lag_c};
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cnt_next     = total_c;
                p_valid_next = 1'b1;
                p_first_next = first_c;
                e_next       = e_reg + 1'b1;
                if (e_reg == n_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (total_c <= {1'b0, k_reg})
                begin
                    r_next = trial_c;
                end
                e_next   = '0;
                cnt_next = '0;
                if (bit_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.order_value = r_reg;
                    out_next.line_done   = last_reg && (b_reg == '0);
                    out_next.run_last    = !last_reg || (b_reg == '0);
                    if (last_reg && (b_reg != '0))
                    begin
                        b_next     = b_reg - 1'b1;
                        bit_next   = BIT_W'(SAMPLE_W - 1);
                        r_next     = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            p_valid_reg   <= 1'b0;
            left_reg      <= RST_LEFT_OFFSET;
            right_reg     <= RST_RIGHT_OFFSET;
            kth_reg       <= RST_KTH_INDEX;
            first_reg     <= '0;
            seen_reg      <= '0;
            wr_ptr_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            p_valid_reg   <= p_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LEFT_OFFSET:  left_reg  <= signed'(cfg_data);
                    CFG_RIGHT_OFFSET: right_reg <= signed'(cfg_data);
                    CFG_KTH_INDEX:    kth_reg   <= cfg_data;
                    default:          ;
                endcase
            end
            if (in_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                if (in_data.line_end)
                begin
                    // line over: start the next line empty
                    seen_reg  <= '0;
                    first_reg <= '0;
                end
                else
                begin
                    seen_reg  <= seen_new;
                    first_reg <= (seen_reg == '0) ? s_sat : first_reg;
                end
            end
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        b_reg       <= b_next;
        last_reg    <= last_next;
        newest_reg  <= newest_next;
        wseen_reg   <= wseen_next;
        wfirst_reg  <= wfirst_next;
        e_reg       <= e_next;
        bit_reg     <= bit_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        p_first_reg <= p_first_next;
        out_reg     <= out_next;
    end

endmodule

// ===== tb/sliding_window_kth_order_filter_test.sv =====
// ----------------------------------------------------------------------------
// sliding_window_kth_order_filter_test
// self-checking bench for the sliding window kth order filter: lines of
// samples go in over a valid/ready channel, every result is checked field by
// field against an in-bench predictor of the windowed kth order statistic,
// across several register settings, random idling and long output stalls
// ----------------------------------------------------------------------------
module sliding_window_kth_order_filter_test;
    import swkf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 64;
    // every item flushing 32 results of the widest window stays well below this
    localparam int CYCLE_LIMIT = 60000000;
    localparam int SETTLE_CYCLES = 1000;
    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sliding_window_kth_order_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the block state and its registers
    logic [SAMPLE_W-1:0] ring [RING_DEPTH];
    logic [SAMPLE_W-1:0] line_first;
    int unsigned         line_count;
    int unsigned         ring_wr;
    logic signed [CFG_W-1:0] win_left;
    logic signed [CFG_W-1:0] win_right;
    logic [CFG_W-1:0]        rank_sel;

    out_item_t ranks_due [$];

    int mismatches;
    int cycles;

    // sender idling control
    bit gaps_on;
    int burst_left;

    // receiver stall control
    bit stall_on;
    int hold_token;
    int hold_seen;
    int hold_left;
    int hold_len;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sliding_window_kth_order_filter_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // sample d positions before the newest, clamped to the line start
    function automatic logic [SAMPLE_W-1:0] look_back(int d, int unsigned newest);
        int unsigned back;
        if (d < 0)
            d = 0;
        if (d >= line_count)
            return line_first;
        back = d % RING_DEPTH;
        return ring[(newest + RING_DEPTH - back) % RING_DEPTH];
    endfunction

    // kth smallest in the window of the position b places behind the newest
    function automatic logic [SAMPLE_W-1:0] window_rank(int b, int lo, int hi,
                                                        int unsigned newest);
        logic [SAMPLE_W-1:0] vals [64];
        int n;
        int k;
        int less;
        int same;
        n = 0;
        for (int off = lo; off <= hi && n < 64; off++)
        begin
            vals[n] = look_back(b - off, newest);
            n++;
        end
        k = rank_sel;
        if (k > n - 1)
            k = n - 1;
        for (int i = 0; i < n; i++)
        begin
            less = 0;
            same = 0;
            for (int j = 0; j < n; j++)
            begin
                if (vals[j] < vals[i])
                    less++;
                else if (vals[j] == vals[i])
                    same++;
            end
            if (less <= k && k < less + same)
                return vals[i];
        end
        return vals[0];
    endfunction

    // update the state for one accepted sample and queue its results
    task automatic predict_ranks(in_item_t it);
        int lo;
        int hi;
        int lag;
        int b;
        int unsigned newest;
        out_item_t r;
        lo = win_left;
        hi = (win_right < win_left) ? lo : int'(win_right);
        lag = (hi > 0) ? hi : 0;
        if (line_count == 0)
            line_first = it.sample;
        newest = ring_wr;
        ring[newest] = it.sample;
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (line_count < 64)
            line_count++;
        if (!it.line_end)
        begin
            if (line_count > lag)
            begin
                r.order_value = window_rank(lag, lo, hi, newest);
                r.line_done = 1'b0;
                r.run_last = 1'b1;
                ranks_due.push_back(r);
            end
        end
        else
        begin
            // flush every pending position of the line
            b = (lag < int'(line_count) - 1) ? lag : int'(line_count) - 1;
            for (; b >= 0; b--)
            begin
                r.order_value = window_rank(b, lo, hi, newest);
                r.line_done = (b == 0);
                r.run_last = (b == 0);
                ranks_due.push_back(r);
            end
            line_count = 0;
            line_first = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (ranks_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %0d done %0b last %0b",
                             out_data.order_value, out_data.line_done,
                             out_data.run_last);
            end
            else
            begin
                want = ranks_due.pop_front();
                if (want !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected value %0d done %0b last %0b, got %0d %0b %0b",
                                 want.order_value, want.line_done, want.run_last,
                                 out_data.order_value, out_data.line_done,
                                 out_data.run_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall pattern plus long hold-offs on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_on)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // shared driver tasks
    // ------------------------------------------------------------------

    // offer one sample, keep valid high after acceptance unless a gap follows
    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic last);
        in_item_t it;
        it.sample = s;
        it.line_end = last;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_ranks(it);
        burst_left--;
        if (gaps_on && burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    task automatic send_line(int len, int lo_val, int hi_val);
        for (int i = 0; i < len; i++)
            send_sample($urandom_range(lo_val, hi_val), i == len - 1);
    endtask

    // stop offering and wait for every queued result, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ranks_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LEFT_OFFSET)
            win_left = val;
        else if (idx == CFG_RIGHT_OFFSET)
            win_right = val;
        else if (idx == CFG_KTH_INDEX)
            rank_sel = val;
        @(posedge clk);
    endtask

    task automatic set_window(int lo, int hi, int k);
        wait_drained();
        write_reg(CFG_LEFT_OFFSET, lo[CFG_W-1:0]);
        write_reg(CFG_RIGHT_OFFSET, hi[CFG_W-1:0]);
        write_reg(CFG_KTH_INDEX, k[CFG_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: 3-tap window, rank 1 (median), extreme sample values
    task automatic test_reset_window();
        send_sample(12'd0, 1'b0);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'hAAA, 1'b0);
        send_sample(12'h555, 1'b0);
        send_sample(12'd0, 1'b0);
        send_sample(12'hFFF, 1'b1);
        // a line of one sample, no longer than the lag
        send_sample(12'h123, 1'b1);
        wait_drained();
    endtask

    // the corner cases of the window registers
    task automatic test_window_corners();
        // right below left collapses to one position
        set_window(3, -2, 0);
        send_line(5, 0, 4095);
        // rank past the window clamps to the largest
        set_window(-2, 2, 62);
        send_line(6, 0, 4095);
        // lag of zero, every sample gives a result at once
        set_window(-4, 0, 2);
        send_line(6, 0, 4095);
        // widest pattern: left of -32, window of 64
        set_window(-32, 31, 63);
        send_line(3, 0, 4095);
        // long lag with a short line, all results come from the flush
        set_window(-31, 31, 0);
        send_line(2, 0, 4095);
        wait_drained();
    endtask

    // long output stall while the sender keeps offering, then a full pause
    task automatic test_output_stall();
        set_window(-1, 2, 1);
        hold_len = 3000;
        hold_token <= hold_token + 1;
        gaps_on = 1'b0;
        send_line(24, 0, 4095);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // random lines, mostly short windows with a few wide and raw settings
    task automatic test_random_lines();
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < 350)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    set_window($urandom_range(0, 4) - 4, $urandom_range(0, 4) - 1,
                               $urandom_range(0, 9));
                else
                    set_window($urandom_range(0, 63) - 32, $urandom_range(0, 63) - 32,
                               $urandom_range(0, 63));
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80)
                                              : $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0)
                send_line(len, 4090, 4095);
            else
                send_line(len, 0, 4095);
            sent += len;
        end
        gaps_on = 1'b1;
        stall_on = 1'b1;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        hold_token = 0;
        hold_seen = 0;
        hold_left = 0;
        hold_len = 0;
        gaps_on = 1'b1;
        stall_on = 1'b1;
        burst_left = 4;
        line_first = '0;
        line_count = 0;
        ring_wr = 0;
        win_left = RST_LEFT_OFFSET;
        win_right = RST_RIGHT_OFFSET;
        rank_sel = RST_KTH_INDEX;
        for (int i = 0; i < RING_DEPTH; i++)
            ring[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_corners();
        test_output_stall();
        test_random_lines();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && ranks_due.size() == 0)
            $display("sliding_window_kth_order_filter_test OK");
        else
            $display("sliding_window_kth_order_filter_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
sv/swkf_pkg.sv
sv/swkf_ram.sv
sv/sliding_window_kth_order_filter.sv
tb/sliding_window_kth_order_filter_test.sv
